FILE: src/lrfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrfc_pkg
// Shared types, constants and the byte-wide CRC-32 step of the log record
// frame checker.
// ----------------------------------------------------------------------------
package lrfc_pkg;

    localparam logic [31:0] MIN_ENTRY  = 32'd21;
    localparam logic [31:0] FIXED_BODY = 32'd17;
    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
    localparam int          QUEUE_DEPTH = 2;

    localparam logic [1:0] REG_EXP_DIM = 2'd0;
    localparam logic [1:0] REG_SINGLE  = 2'd1;
    localparam logic [1:0] REG_INS     = 2'd2;
    localparam logic [1:0] REG_DEL     = 2'd3;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_TRUNC     = 4'd1;
    localparam logic [3:0] ST_SMALL     = 4'd2;
    localparam logic [3:0] ST_PAST      = 4'd3;
    localparam logic [3:0] ST_CRC       = 4'd4;
    localparam logic [3:0] ST_TYPE      = 4'd5;
    localparam logic [3:0] ST_ALIGN     = 4'd6;
    localparam logic [3:0] ST_DIM       = 4'd7;
    localparam logic [3:0] ST_DEL_PAY   = 4'd8;
    localparam logic [3:0] ST_TRAILING  = 4'd9;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } lrfc_in_t;

    typedef struct packed {
        logic        result_kind;
        logic [31:0] vector_word;
        logic [29:0] word_index;
        logic        record_is_delete;
        logic signed [63:0] stamp_ms;
        logic [63:0] block_number;
        logic [29:0] vector_count;
        logic [3:0]  status;
    } lrfc_out_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: src/lrfc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrfc_front
// Accepts request bytes and passes them into a two-entry work queue that
// decouples the input channel from the parser.
// ----------------------------------------------------------------------------
module lrfc_front
    import lrfc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire lrfc_in_t in_item,
    input  wire logic     in_valid,
    output logic          in_ready,
    output lrfc_in_t      q_item,
    output logic          q_valid,
    input  wire logic     q_ready
);

    lrfc_in_t                mem_reg [QUEUE_DEPTH];
    logic                    wp_reg, rp_reg;
    logic [1:0]              cnt_reg;
    logic                    push, pop;

    assign in_ready = (cnt_reg != 2'(QUEUE_DEPTH));
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk) begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule
`default_nettype wire

FILE: src/lrfc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrfc_back
// Parses one byte per cycle when not stalled: size prefix, body fields,
// vector words, CRC and end-of-frame checks. Results go to an output register.
// ----------------------------------------------------------------------------
module lrfc_back
    import lrfc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [29:0] cfg_data,
    input  wire lrfc_in_t    q_item,
    input  wire logic        q_valid,
    output logic             q_ready,
    output lrfc_out_t        out_item,
    output logic             out_valid,
    input  wire logic        out_ready
);

    logic [29:0] exp_dim_reg;
    logic        single_reg;
    logic [7:0]  ins_code_reg, del_code_reg;

    logic        phase_reg, phase_next;
    logic [31:0] size_reg, size_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] rcrc_reg, rcrc_next;
    logic [63:0] stamp_reg, stamp_next;
    logic [63:0] block_reg, block_next;
    logic [7:0]  type_reg, type_next;
    logic [23:0] asm_reg, asm_next;
    logic        skip_reg, skip_next;

    lrfc_out_t   res_reg, res;
    logic        res_valid_reg, emit;

    logic [7:0]  b;
    logic        last, is_ins, is_del, take;
    logic [31:0] pos, frame_body_len, payload_len, cnt_inc, pv;
    logic [3:0]  st;

    assign q_ready   = !res_valid_reg || out_ready;
    assign take      = q_valid && q_ready;
    assign out_item  = res_reg;
    assign out_valid = res_valid_reg;
    assign b         = q_item.data_byte;
    assign last      = q_item.buffer_end;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            exp_dim_reg  <= '0;
            single_reg   <= 1'b0;
            ins_code_reg <= 8'd1;
            del_code_reg <= 8'd2;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_EXP_DIM: exp_dim_reg  <= cfg_data;
                REG_SINGLE:  single_reg   <= cfg_data[0];
                REG_INS:     ins_code_reg <= cfg_data[7:0];
                REG_DEL:     del_code_reg <= cfg_data[7:0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        phase_next = phase_reg;
        size_next  = size_reg;
        cnt_next   = cnt_reg;
        crc_next   = crc_reg;
        rcrc_next  = rcrc_reg;
        stamp_next = stamp_reg;
        block_next = block_reg;
        type_next  = type_reg;
        asm_next   = asm_reg;
        skip_next  = skip_reg;
        emit       = 1'b0;
        res        = '0;
        st         = ST_OK;
        pos        = cnt_reg;
        frame_body_len = size_reg - 32'd4;
        payload_len    = frame_body_len - FIXED_BODY;
        pv         = pos - FIXED_BODY;
        cnt_inc    = cnt_reg + 32'd1;
        is_ins     = (type_reg == ins_code_reg);
        is_del     = !is_ins && (type_reg == del_code_reg);
        if (skip_reg)
        begin
            if (last)
            begin
                skip_next  = 1'b0;
                phase_next = 1'b0;
                cnt_next   = '0;
                size_next  = '0;
            end
        end
        else if (!phase_reg)
        begin
            size_next = {b, size_reg[31:8]};
            cnt_next  = cnt_inc;
            if (cnt_inc < 32'd4)
            begin
                if (last)
                begin
                    emit = 1'b1;
                    st   = ST_TRUNC;
                end
            end
            else if (size_next < MIN_ENTRY)
            begin
                emit = 1'b1;
                st   = ST_SMALL;
                skip_next = !last;
            end
            else if (last)
            begin
                emit = 1'b1;
                st   = ST_PAST;
            end
            else
            begin
                phase_next = 1'b1;
                cnt_next   = '0;
                crc_next   = '1;
                rcrc_next  = '0;
                stamp_next = '0;
                block_next = '0;
                type_next  = '0;
                asm_next   = '0;
            end
            if (emit)
            begin
                cnt_next  = '0;
                size_next = '0;
            end
        end
        else
        begin
            if (pos < frame_body_len)
            begin
                crc_next = crc_byte(crc_reg, b);
                if (pos == 32'd0)
                begin
                    type_next = b;
                end
                else if (pos <= 32'd8)
                begin
                    stamp_next = {b, stamp_reg[63:8]};
                end
                else if (pos < FIXED_BODY)
                begin
                    block_next = {b, block_reg[63:8]};
                end
                else if (pv[1:0] == 2'd3)
                begin
                    asm_next = '0;
                    if (is_ins)
                    begin
                        emit = 1'b1;
                        res.vector_word  = {b, asm_reg};
                        res.word_index   = pv[31:2];
                        res.stamp_ms     = stamp_reg;
                        res.block_number = block_reg;
                    end
                end
                else
                begin
                    asm_next = {b, asm_reg[23:8]};
                end
            end
            else
            begin
                rcrc_next = {b, rcrc_reg[31:8]};
            end
            cnt_next = cnt_inc;
            if (cnt_inc == size_reg)
            begin
                emit = 1'b1;
                res  = '0;
                if (rcrc_next != ~crc_next)
                begin
                    st = ST_CRC;
                end
                else if (is_ins)
                begin
                    if (payload_len[1:0] != 2'd0)
                    begin
                        st = ST_ALIGN;
                    end
                    else if (exp_dim_reg != '0 && payload_len[31:2] != exp_dim_reg)
                    begin
                        st = ST_DIM;
                    end
                end
                else if (is_del)
                begin
                    if (frame_body_len != FIXED_BODY)
                    begin
                        st = ST_DEL_PAY;
                    end
                end
                else
                begin
                    st = ST_TYPE;
                end
                if (st == ST_OK && single_reg && !last)
                begin
                    st = ST_TRAILING;
                end
                if (st == ST_OK)
                begin
                    res.record_is_delete = is_del;
                    res.stamp_ms         = stamp_reg;
                    res.block_number     = block_reg;
                    res.vector_count     = is_ins ? payload_len[31:2] : 30'd0;
                end
                else
                begin
                    skip_next = !last;
                end
                phase_next = 1'b0;
                cnt_next   = '0;
                size_next  = '0;
            end
            else if (last)
            begin
                emit = 1'b1;
                res  = '0;
                st   = ST_PAST;
                phase_next = 1'b0;
                cnt_next   = '0;
                size_next  = '0;
            end
        end
        if (st != ST_OK || res.result_kind)
        begin
            res.result_kind = 1'b1;
        end
        if (emit && (st != ST_OK || (phase_reg && cnt_inc == size_reg && !skip_reg)))
        begin
            res.result_kind = 1'b1;
        end
        res.status = st;
    end

    always_ff @(posedge clk) begin
        if (take && emit)
        begin
            res_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            phase_reg     <= 1'b0;
            size_reg      <= '0;
            cnt_reg       <= '0;
            crc_reg       <= '1;
            rcrc_reg      <= '0;
            stamp_reg     <= '0;
            block_reg     <= '0;
            type_reg      <= '0;
            asm_reg       <= '0;
            skip_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                phase_reg <= phase_next;
                size_reg  <= size_next;
                cnt_reg   <= cnt_next;
                crc_reg   <= crc_next;
                rcrc_reg  <= rcrc_next;
                stamp_reg <= stamp_next;
                block_reg <= block_next;
                type_reg  <= type_next;
                asm_reg   <= asm_next;
                skip_reg  <= skip_next;
            end
            if (take && emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

FILE: src/log_record_frame_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// log_record_frame_checker
// Byte-stream parser for size-prefixed, CRC-32 protected log records.
//
// Input channel in_valid/in_ready carries one request byte plus a buffer-end
// flag. Output channel out_valid/out_ready carries provisional vector words
// and one status result at each frame end or error.
// A request byte enters a two-entry queue, is parsed by the back end, and any
// result it causes is registered in the output register. Throughput is one
// byte per cycle while the receiver does not stall, set by the byte-wide CRC
// step and field shift in the back end.
// When the receiver stalls, the output register holds its result and the
// parser stops; the queue fills with up to two bytes, then in_ready drops.
// Reset clears the queue and the parser to wait for a size prefix and loads
// the register defaults (insert type 1, delete type 2).
// Configuration: cfg_we with cfg_index and cfg_data, one write per cycle.
// ----------------------------------------------------------------------------
module log_record_frame_checker
    import lrfc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [29:0] cfg_data,
    input  wire lrfc_in_t    in_item,
    input  wire logic        in_valid,
    output logic             in_ready,
    output lrfc_out_t        out_item,
    output logic             out_valid,
    input  wire logic        out_ready
);

    lrfc_in_t q_item;
    logic     q_valid, q_ready;

    lrfc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_item    (in_item),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .q_item     (q_item),
        .q_valid    (q_valid),
        .q_ready    (q_ready)
    );

    lrfc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_item     (q_item),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .out_item   (out_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready)
    );

endmodule
`default_nettype wire

FILE: tb/sv/lrfc_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrfc_scoreboard
// Watches the configuration port and both channels of the log record
// frame checker, predicts every word and status result from accepted bytes,
// and compares the results the block returns, field by field, in order.
// ----------------------------------------------------------------------------
module lrfc_scoreboard
    import lrfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [29:0] cfg_data,
    input  lrfc_in_t    in_item,
    input  logic        in_valid,
    input  logic        in_ready,
    input  lrfc_out_t   out_item,
    input  logic        out_valid,
    input  logic        out_ready,
    output int          fail_count,
    output int          outstanding
);

    logic [29:0] dim_cfg;
    logic        single_cfg;
    logic [7:0]  ins_code;
    logic [7:0]  del_code;

    logic        in_body;
    logic        skipping;
    logic [31:0] fsize;
    logic [31:0] byte_cnt;
    logic [31:0] crc_acc;
    logic [31:0] crc_rx;
    logic [63:0] stamp_acc;
    logic [63:0] block_acc;
    logic [7:0]  type_acc;
    logic [23:0] word_acc;

    lrfc_out_t   pending_results[$];

    function automatic logic [31:0] crc_update(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        repeat (8)
        begin
            if (x[0])
                x = {1'b0, x[31:1]} ^ 32'hEDB88320;
            else
                x = {1'b0, x[31:1]};
        end
        return x;
    endfunction

    function automatic bit abort_frame(output lrfc_out_t r, input logic [3:0] st,
                                       input bit last);
        r = '0;
        r.result_kind = 1'b1;
        r.status = st;
        in_body = 1'b0;
        byte_cnt = '0;
        fsize = '0;
        skipping = !last;
        return 1'b1;
    endfunction

    function automatic bit parse_byte(input lrfc_in_t it, output lrfc_out_t r);
        logic [7:0]  b;
        bit          last;
        bit          is_ins;
        bit          is_del;
        bit          got;
        logic [31:0] pos;
        logic [31:0] blen;
        logic [31:0] vbytes;
        logic [3:0]  st;
        b = it.data_byte;
        last = it.buffer_end;
        got = 1'b0;
        r = '0;
        if (skipping)
        begin
            if (last)
            begin
                skipping = 1'b0;
                in_body = 1'b0;
                byte_cnt = '0;
                fsize = '0;
            end
            return 1'b0;
        end
        if (!in_body)
        begin
            fsize = {b, fsize[31:8]};
            byte_cnt = byte_cnt + 1;
            if (byte_cnt < 4)
                return last ? abort_frame(r, ST_TRUNC, 1'b1) : 1'b0;
            if (fsize < MIN_ENTRY)
                return abort_frame(r, ST_SMALL, last);
            if (last)
                return abort_frame(r, ST_PAST, 1'b1);
            in_body = 1'b1;
            byte_cnt = '0;
            crc_acc = '1;
            crc_rx = '0;
            stamp_acc = '0;
            block_acc = '0;
            type_acc = '0;
            word_acc = '0;
            return 1'b0;
        end
        pos = byte_cnt;
        blen = fsize - 4;
        is_ins = (type_acc == ins_code);
        is_del = !is_ins && (type_acc == del_code);
        if (pos < blen)
        begin
            crc_acc = crc_update(crc_acc, b);
            if (pos == 0)
                type_acc = b;
            else if (pos <= 8)
                stamp_acc = {b, stamp_acc[63:8]};
            else if (pos < FIXED_BODY)
                block_acc = {b, block_acc[63:8]};
            else if (((pos - FIXED_BODY) & 3) == 3)
            begin
                if (is_ins)
                begin
                    r.vector_word = {b, word_acc};
                    r.word_index = 30'((pos - FIXED_BODY) >> 2);
                    r.stamp_ms = stamp_acc;
                    r.block_number = block_acc;
                    got = 1'b1;
                end
                word_acc = '0;
            end
            else
                word_acc = {b, word_acc[23:8]};
        end
        else
            crc_rx = {b, crc_rx[31:8]};
        byte_cnt = pos + 1;
        if (byte_cnt == fsize)
        begin
            st = ST_OK;
            vbytes = blen - FIXED_BODY;
            if (crc_rx != ~crc_acc)
                st = ST_CRC;
            else if (is_ins)
            begin
                if (vbytes[1:0] != 0)
                    st = ST_ALIGN;
                else if (dim_cfg != 0 && 30'(vbytes >> 2) != dim_cfg)
                    st = ST_DIM;
            end
            else if (is_del)
            begin
                if (blen != FIXED_BODY)
                    st = ST_DEL_PAY;
            end
            else
                st = ST_TYPE;
            if (st == ST_OK && single_cfg && !last)
                st = ST_TRAILING;
            if (st != ST_OK)
                return abort_frame(r, st, last);
            r = '0;
            r.result_kind = 1'b1;
            r.record_is_delete = is_del;
            r.stamp_ms = stamp_acc;
            r.block_number = block_acc;
            r.vector_count = is_ins ? 30'(vbytes >> 2) : 30'd0;
            in_body = 1'b0;
            byte_cnt = '0;
            fsize = '0;
            return 1'b1;
        end
        if (last)
            return abort_frame(r, ST_PAST, 1'b1);
        return got;
    endfunction

    function automatic bit field_ok(string name, logic [63:0] e, logic [63:0] a);
        if (e !== a)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, e, a);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lrfc_out_t exp_r;
        lrfc_out_t new_r;
        bit ok;
        if (!rst_n)
        begin
            dim_cfg = '0;
            single_cfg = 1'b0;
            ins_code = 8'd1;
            del_code = 8'd2;
            in_body = 1'b0;
            skipping = 1'b0;
            fsize = '0;
            byte_cnt = '0;
            crc_acc = '1;
            crc_rx = '0;
            stamp_acc = '0;
            block_acc = '0;
            type_acc = '0;
            word_acc = '0;
            pending_results.delete();
            fail_count = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_EXP_DIM: dim_cfg = cfg_data;
                    REG_SINGLE:  single_cfg = cfg_data[0];
                    REG_INS:     ins_code = cfg_data[7:0];
                    REG_DEL:     del_code = cfg_data[7:0];
                    default:     ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result expected none actual %p", $time,
                             out_item);
                    fail_count++;
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    ok = field_ok("result_kind", exp_r.result_kind, out_item.result_kind);
                    ok &= field_ok("vector_word", exp_r.vector_word, out_item.vector_word);
                    ok &= field_ok("word_index", exp_r.word_index, out_item.word_index);
                    ok &= field_ok("record_is_delete", exp_r.record_is_delete,
                                   out_item.record_is_delete);
                    ok &= field_ok("stamp_ms", exp_r.stamp_ms, out_item.stamp_ms);
                    ok &= field_ok("block_number", exp_r.block_number,
                                   out_item.block_number);
                    ok &= field_ok("vector_count", exp_r.vector_count,
                                   out_item.vector_count);
                    ok &= field_ok("status", exp_r.status, out_item.status);
                    if (!ok)
                        fail_count++;
                end
            end
            if (in_valid && in_ready)
            begin
                if (parse_byte(in_item, new_r))
                    pending_results = {pending_results, new_r};
            end
            outstanding = pending_results.size();
        end
    end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Log record frame checker test: builds log buffers of good and damaged
// records under several register settings, streams them with random gaps and
// receiver stalls, and reports the scoreboard verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import lrfc_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int PHASE_BYTES = 135;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [29:0] cfg_data;
    lrfc_in_t    in_item;
    logic        in_valid;
    logic        in_ready;
    lrfc_out_t   out_item;
    logic        out_valid;
    logic        out_ready;
    int          fail_count;
    int          outstanding;
    int          idle_cycles;
    bit          hold_req;

    logic [29:0] cur_dim;
    logic        cur_single;
    logic [7:0]  cur_ins;
    logic [7:0]  cur_del;
    lrfc_in_t    byte_q[$];

    log_record_frame_checker dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_item(in_item), .in_valid(in_valid),
        .in_ready(in_ready), .out_item(out_item), .out_valid(out_valid),
        .out_ready(out_ready)
    );

    lrfc_scoreboard scoreboard (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_item(in_item), .in_valid(in_valid),
        .in_ready(in_ready), .out_item(out_item), .out_valid(out_valid),
        .out_ready(out_ready), .fail_count(fail_count), .outstanding(outstanding)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // receiver: random stalls, one long hold when asked
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (300) @(negedge clk);
            end
            else if ($urandom_range(0, 99) < 55)
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(negedge clk);
            end
            else
            begin
                out_ready <= 1'b0;
                if ($urandom_range(0, 99) < 5)
                    repeat ($urandom_range(20, 60)) @(negedge clk);
                else
                    repeat ($urandom_range(1, 3)) @(negedge clk);
            end
        end
    end

    function automatic logic [31:0] crc_of(input logic [7:0] body[$]);
        logic [31:0] c;
        c = '1;
        foreach (body[i])
        begin
            c ^= {24'd0, body[i]};
            for (int k = 0; k < 8; k++)
                c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
        end
        return ~c;
    endfunction

    task automatic push_byte(input logic [7:0] b);
        lrfc_in_t it;
        it.data_byte = b;
        it.buffer_end = 1'b0;
        byte_q = {byte_q, it};
    endtask

    task automatic push_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            push_byte(w[8*i +: 8]);
    endtask

    // kinds: 0 insert, 1 delete, 2 bad crc, 3 unknown type, 4 misaligned,
    // 5 wrong dimension, 6 delete with payload, 7 short size, 8 noise
    task automatic add_record(input int kind);
        logic [7:0]  body[$];
        logic [7:0]  typ;
        logic [31:0] crc;
        int          vbytes;
        int          n_ok;
        n_ok = (cur_dim != 0 && cur_dim <= 6) ? int'(cur_dim) : $urandom_range(0, 5);
        typ = cur_ins;
        vbytes = 0;
        case (kind)
            0, 2: vbytes = 4 * n_ok;
            1: typ = cur_del;
            3:
            begin
                do typ = 8'($urandom_range(0, 255));
                while (typ == cur_ins || typ == cur_del);
                vbytes = $urandom_range(0, 8);
            end
            4: vbytes = 4 * $urandom_range(0, 3) + $urandom_range(1, 3);
            5: vbytes = (cur_dim != 0 && cur_dim <= 6) ? 4 * (n_ok + 1)
                                                       : 4 * $urandom_range(0, 3);
            6:
            begin
                typ = cur_del;
                vbytes = $urandom_range(1, 6);
            end
            7:
            begin
                push_word(32'($urandom_range(0, 20)));
                return;
            end
            default:
            begin
                repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
                return;
            end
        endcase
        body = {body, typ};
        repeat (16 + vbytes) body = {body, 8'($urandom_range(0, 255))};
        crc = crc_of(body);
        if (kind == 2)
            crc ^= 32'(1) << $urandom_range(0, 31);
        push_word(32'(body.size() + 4));
        foreach (body[i])
            push_byte(body[i]);
        push_word(crc);
    endtask

    task automatic add_buffer();
        int start;
        int r;
        int cut;
        start = byte_q.size();
        repeat ($urandom_range(1, 3))
        begin
            r = $urandom_range(0, 99);
            add_record(r < 45 ? 0 : r < 60 ? 1 : $urandom_range(2, 8));
        end
        if ($urandom_range(0, 7) == 0 && byte_q.size() - start > 1)
        begin
            cut = $urandom_range(1, byte_q.size() - start - 1);
            repeat (cut) void'(byte_q.pop_back());
        end
        byte_q[byte_q.size() - 1].buffer_end = 1'b1;
    endtask

    task automatic send_all();
        int gap;
        int r;
        while (byte_q.size() > 0)
        begin
            r = $urandom_range(0, 99);
            gap = r < 70 ? 0 : r < 95 ? $urandom_range(1, 3) : $urandom_range(10, 40);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_item <= byte_q.pop_front();
            in_valid <= 1'b1;
            do @(posedge clk);
            while (!in_ready);
            @(negedge clk);
        end
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (outstanding != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [29:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_phase(input logic [29:0] dim, input logic single,
                             input logic [7:0] ins, input logic [7:0] del, input bit hold);
        wait_drained();
        write_reg(REG_EXP_DIM, dim);
        write_reg(REG_SINGLE, {29'd0, single});
        write_reg(REG_INS, {22'd0, ins});
        write_reg(REG_DEL, {22'd0, del});
        cur_dim = dim;
        cur_single = single;
        cur_ins = ins;
        cur_del = del;
        while (byte_q.size() < PHASE_BYTES)
            add_buffer();
        if (hold)
            hold_req = 1'b1;
        send_all();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_item = '0;
        in_valid = 1'b0;
        hold_req = 1'b0;
        idle_cycles = 0;
        cur_dim = '0;
        cur_single = 1'b0;
        cur_ins = 8'd1;
        cur_del = 8'd2;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // prefix cut short, size below minimum, then a bare delete record
        push_byte(8'h55);
        byte_q[0].buffer_end = 1'b1;
        push_word(32'd20);
        byte_q[byte_q.size() - 1].buffer_end = 1'b1;
        add_record(1);
        byte_q[byte_q.size() - 1].buffer_end = 1'b1;
        send_all();

        run_phase(30'd0, 1'b0, 8'd1, 8'd2, 1'b0);
        run_phase(30'd3, 1'b1, 8'd255, 8'd0, 1'b1);
        run_phase(30'h3FFFFFFF, 1'b0, 8'd0, 8'd255, 1'b0);
        run_phase(30'd2, 1'b0, 8'd7, 8'd7, 1'b0);
        run_phase(30'($urandom_range(0, 6)), 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0);

        while (outstanding != 0)
            @(negedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
